/* rtl/core/dsm_pkg.sv */
`default_nettype none

package dsm_pkg;

  localparam int SYMBOL_W = 8;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;

  // Item kind codes carried on the input channel.
  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // One pattern token: literal byte, dot wildcard flag and star flag.
  typedef struct packed {
    logic                star;
    logic                any;
    logic [SYMBOL_W-1:0] literal;
  } token_t;

  // Token write request toward the token store.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] idx;
    token_t             data;
  } tok_wr_t;

  // Per-byte control toward the row update logic.
  typedef struct packed {
    logic                in_string;
    logic [SYMBOL_W-1:0] symbol;
    logic [COUNT_W-1:0]  used;
  } row_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/dsm_token_store.sv */
`default_nettype none

module dsm_token_store #(
  parameter int MAX_TOKENS = 32
) (
  input  logic              clk,
  input  dsm_pkg::tok_wr_t  wr,
  output dsm_pkg::token_t   tokens [MAX_TOKENS]
);
  import dsm_pkg::*;

  // Only slots reachable by the index field hold storage.
  localparam int DEPTH = (MAX_TOKENS < (1 << INDEX_W)) ? MAX_TOKENS : (1 << INDEX_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  token_t tok_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en && ({1'b0, wr.idx} < COUNT_W'(DEPTH))) begin
      tok_r[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

  for (genvar k = 0; k < MAX_TOKENS; k++) begin : g_out
    if (k < DEPTH) begin : g_slot
      assign tokens[k] = tok_r[k];
    end else begin : g_none
      assign tokens[k] = '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dsm_row_update.sv */
`default_nettype none

module dsm_row_update #(
  parameter int MAX_TOKENS = 32
) (
  input  dsm_pkg::token_t   tokens [MAX_TOKENS],
  input  dsm_pkg::row_ctl_t ctl,
  input  logic [MAX_TOKENS:0] old_row,
  output logic [MAX_TOKENS:0] new_row
);
  import dsm_pkg::*;

  // Lane k handles token k, which drives row position k+1.
  logic [MAX_TOKENS-1:0] en;
  logic [MAX_TOKENS-1:0] star_v;
  logic [MAX_TOKENS-1:0] hit;
  logic [MAX_TOKENS-1:0] gen;
  logic [MAX_TOKENS:0]   star_ext;
  logic [MAX_TOKENS:0]   star_inc;
  logic [MAX_TOKENS:0]   run;
  logic [MAX_TOKENS:0]   start_row;
  logic [MAX_TOKENS:0]   base_row;
  logic [MAX_TOKENS:0]   add_a;
  logic [MAX_TOKENS:0]   add_b;
  logic [MAX_TOKENS:0]   add_s;
  logic [MAX_TOKENS:0]   carry_in;

  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      en[k]     = (COUNT_W'(k + 1) <= ctl.used);
      star_v[k] = en[k] & tokens[k].star;
      hit[k]    = en[k] & (tokens[k].any | (tokens[k].literal == ctl.symbol));
    end
  end

  // Star closure of position zero: the run of starred tokens from the
  // start of the pattern, isolated as the trailing ones of the star vector.
  assign star_ext  = {1'b0, star_v};
  assign star_inc  = star_ext + (MAX_TOKENS + 1)'(1);
  assign run       = star_ext & ~star_inc;
  assign start_row = {run[MAX_TOKENS-1:0], 1'b1};

  assign base_row = ctl.in_string ? old_row : start_row;

  always_comb begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      gen[k] = hit[k] & (star_v[k] ? base_row[k+1] : base_row[k]);
    end
  end

  // new[t] = gen[t] | star[t] & new[t-1] is a carry chain; an adder with
  // generate gen and propagate star resolves it in one pass.
  assign add_a    = {1'b0, gen | star_v};
  assign add_b    = {1'b0, gen};
  assign add_s    = add_a + add_b;
  assign carry_in = add_s ^ add_a ^ add_b;
  assign new_row  = {carry_in[MAX_TOKENS:1], 1'b0};

endmodule

`default_nettype wire

/* rtl/core/dot_star_pattern_matcher.sv */
// Result path: a subject byte marked last goes from the input register to the result
// register, which drives out_valid; the edge that ends its cycle in the input register
// also loads the result register. The active-position row updates fully as a byte advances.
// Throughput: one transaction per cycle, unless a waiting result stalls a last byte.
// Reset (rst_n, synchronous, active low) clears the handshake state, token_count, the
// active-position row and the in-string flag; the token table is not cleared.
`default_nettype none

module dot_star_pattern_matcher #(
  parameter int MAX_TOKENS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel: token writes and subject bytes.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [dsm_pkg::INDEX_W-1:0]  in_token_index,
  input  logic [dsm_pkg::SYMBOL_W-1:0] in_symbol,
  input  logic                         in_token_any,
  input  logic                         in_token_star,
  input  logic                         in_last,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_matched,
  // Configuration: token_count.
  input  logic                         cfg_we,
  input  logic [dsm_pkg::COUNT_W-1:0]  cfg_wdata
);
  import dsm_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_TOKENS);
  localparam int SEL_W = $clog2(MAX_TOKENS + 1);

  // Input register. Every transaction lands here first; from here it is
  // either applied to the token table or used to advance the row.
  logic                s1_valid_r;
  logic                s1_kind_r;
  logic [INDEX_W-1:0]  s1_idx_r;
  logic [SYMBOL_W-1:0] s1_symbol_r;
  logic                s1_any_r;
  logic                s1_star_r;
  logic                s1_last_r;

  // Matcher state.
  logic [COUNT_W-1:0]  count_r;
  logic [MAX_TOKENS:0] act_r;
  logic                in_string_r;

  // Result register.
  logic                out_valid_r;
  logic                out_matched_r;

  logic                s1_has_result;
  logic                advance;
  logic                byte_go;
  logic                result_go;
  logic [COUNT_W-1:0]  used;
  logic [MAX_TOKENS:0] new_row;
  logic                matched_nxt;
  tok_wr_t             tok_wr;
  row_ctl_t            row_ctl;
  token_t              tokens [MAX_TOKENS];

  // Only a last subject byte produces a result, so only such an item has to
  // wait for a free result register. Token writes and other bytes move on
  // even while a result is still waiting to be taken.
  assign s1_has_result = (s1_kind_r == KIND_BYTE) && s1_last_r;
  assign advance   = s1_valid_r && (!s1_has_result || !out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign byte_go   = advance && (s1_kind_r == KIND_BYTE);
  assign result_go = byte_go && s1_last_r;

  // A count above capacity is used as the capacity.
  assign used = (count_r > MAX_CNT) ? MAX_CNT : count_r;

  assign tok_wr.en           = advance && (s1_kind_r == KIND_TOKEN);
  assign tok_wr.idx          = s1_idx_r;
  assign tok_wr.data.star    = s1_star_r;
  assign tok_wr.data.any     = s1_any_r;
  assign tok_wr.data.literal = s1_symbol_r;

  dsm_token_store #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_store (
    .clk    (clk),
    .wr     (tok_wr),
    .tokens (tokens)
  );

  assign row_ctl.in_string = in_string_r;
  assign row_ctl.symbol    = s1_symbol_r;
  assign row_ctl.used      = used;

  dsm_row_update #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_row (
    .tokens  (tokens),
    .ctl     (row_ctl),
    .old_row (act_r),
    .new_row (new_row)
  );

  // The whole string matches when the position past the last token is live.
  assign matched_nxt = new_row[used[SEL_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      act_r       <= '0;
      in_string_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (byte_go) begin
        act_r       <= new_row;
        in_string_r <= !s1_last_r;
      end
      if (result_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r   <= in_kind;
      s1_idx_r    <= in_token_index;
      s1_symbol_r <= in_symbol;
      s1_any_r    <= in_token_any;
      s1_star_r   <= in_token_star;
      s1_last_r   <= in_last;
    end
    if (result_go) begin
      out_matched_r <= matched_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

`default_nettype wire

/* rtl/core/dsm_checker.sv */
`default_nettype none

module dsm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_matched
);
  import dsm_pkg::*;

  // A waiting result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched))
    else $error("result changed or dropped while stalled");

  // Reset empties the result register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result must trace back to a last subject byte taken on the input channel.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_kind == KIND_BYTE) && in_last, 2))
    else $error("result without a matching last byte");

  // The input side stalls only behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

bind dot_star_pattern_matcher dsm_checker u_dsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_kind     (in_kind),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_matched (out_matched)
);

`default_nettype wire
